// File: rtl/core/aivd_pkg.sv
`timescale 1ns / 1ps

package aivd_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned FieldW = 4;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_PAYLOAD_FIELD = 2'd0;
  localparam logic [1:0] REG_COUNT_FIELD   = 2'd1;
  localparam logic [1:0] REG_NUMBER_FIELD  = 2'd2;

  localparam logic [FieldW-1:0] PAYLOAD_FIELD_RST = 4'd5;
  localparam logic [FieldW-1:0] COUNT_FIELD_RST   = 4'd1;
  localparam logic [FieldW-1:0] NUMBER_FIELD_RST  = 4'd2;

  typedef struct packed {
    logic [FieldW-1:0] payload_field;
    logic [FieldW-1:0] count_field;
    logic [FieldW-1:0] number_field;
  } aivd_cfg_t;

  // everything one sentence byte produces: an optional symbol, an optional status
  typedef struct packed {
    logic       has_sym;
    logic [5:0] symbol;
    logic       has_stat;
    logic       checksum_ok;
    logic [7:0] fragment_count;
    logic [7:0] fragment_number;
    logic       has_payload;
  } aivd_run_t;

endpackage

// File: rtl/core/aivd_cfg_regs.sv
`timescale 1ns / 1ps

module aivd_cfg_regs import aivd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output aivd_cfg_t        cfg_o
);

  aivd_cfg_t  cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.payload_field <= PAYLOAD_FIELD_RST;
      cfg_r.count_field   <= COUNT_FIELD_RST;
      cfg_r.number_field  <= NUMBER_FIELD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PAYLOAD_FIELD: cfg_r.payload_field <= pwdata[FieldW-1:0];
        REG_COUNT_FIELD:   cfg_r.count_field   <= pwdata[FieldW-1:0];
        REG_NUMBER_FIELD:  cfg_r.number_field  <= pwdata[FieldW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_PAYLOAD_FIELD: prdata[FieldW-1:0] = cfg_r.payload_field;
      REG_COUNT_FIELD:   prdata[FieldW-1:0] = cfg_r.count_field;
      REG_NUMBER_FIELD:  prdata[FieldW-1:0] = cfg_r.number_field;
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_r;

endmodule

// File: rtl/core/aivd_parse_core.sv
`timescale 1ns / 1ps

module aivd_parse_core import aivd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  aivd_cfg_t cfg_i,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_byte_req,
  input  logic      in_last,
  input  logic      q_ready_i,
  output logic      push_o,
  output aivd_run_t run_o
);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [1:0] PH_EMPTY = 2'd0;
  localparam logic [1:0] PH_DIGIT = 2'd1;
  localparam logic [1:0] PH_ENDED = 2'd2;
  localparam logic [1:0] PH_BAD   = 2'd3;

  // input register
  logic       stage_valid_r;
  logic [7:0] stage_byte_r;
  logic       stage_last_r;
  logic       fire;

  // sentence state
  logic       start_seen_r, start_seen_nxt;
  logic       star_seen_r, star_seen_nxt;
  logic       framing_bad_r, framing_bad_nxt;
  logic       data_seen_r, data_seen_nxt;
  logic [7:0] xor_sum_r, xor_sum_nxt;
  logic [1:0] hex_digits_r, hex_digits_nxt;
  logic [7:0] hex_value_r, hex_value_nxt;
  logic       hex_bad_r, hex_bad_nxt;
  logic [3:0] comma_count_r, comma_count_nxt;
  logic [7:0] count_value_r, count_value_nxt;
  logic [1:0] count_phase_r, count_phase_nxt;
  logic [7:0] number_value_r, number_value_nxt;
  logic [1:0] number_phase_r, number_phase_nxt;
  logic       payload_stopped_r, payload_stopped_nxt;
  logic       payload_nonempty_r, payload_nonempty_nxt;

  logic [7:0] b;
  logic [4:0] hex_nib;
  logic [9:0] cnt_step, num_step;
  logic       emit_sym;
  aivd_run_t  run;

  // {valid, nibble}
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = '0;
      hex_of = '0;
      if (c inside {[8'h30:8'h39]}) begin
        hex_of = {1'b1, c[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
        t = c - 8'h37;
        hex_of = {1'b1, t[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
        t = c - 8'h57;
        hex_of = {1'b1, t[3:0]};
      end
    end
  endfunction

  // {phase, value}
  function automatic logic [9:0] dec_feed(input logic [7:0] c, input logic [7:0] val,
                                          input logic [1:0] ph);
    logic        dig;
    logic [11:0] acc;
    begin
      dig = c inside {[8'h30:8'h39]};
      acc = ({4'b0, val} << 3) + ({4'b0, val} << 1) + {8'b0, c[3:0]};
      dec_feed = {ph, val};
      case (ph)
        PH_EMPTY: dec_feed = dig ? {PH_DIGIT, 4'b0, c[3:0]} : {PH_BAD, val};
        PH_DIGIT: begin
          if (dig) begin
            dec_feed = {PH_DIGIT, (acc > 12'd255) ? 8'd255 : acc[7:0]};
          end else begin
            dec_feed = {PH_ENDED, val};
          end
        end
        default: dec_feed = {ph, val};
      endcase
    end
  endfunction

  function automatic logic [7:0] dec_result(input logic [7:0] val, input logic [1:0] ph);
    begin
      dec_result = (ph inside {PH_DIGIT, PH_ENDED}) ? val : 8'd1;
    end
  endfunction

  function automatic logic [5:0] dearmor(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = c - 8'd48;
      if (v > 8'd40) v = v - 8'd8;
      dearmor = v[5:0];
    end
  endfunction

  assign fire     = stage_valid_r & q_ready_i;
  assign in_ready = ~stage_valid_r | fire;
  assign b        = stage_byte_r;
  assign hex_nib  = hex_of(b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid_r <= 1'b1;
    end else if (fire) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte_r <= in_byte_req;
      stage_last_r <= in_last;
    end
  end

  always_comb begin
    start_seen_nxt       = start_seen_r;
    star_seen_nxt        = star_seen_r;
    framing_bad_nxt      = framing_bad_r;
    data_seen_nxt        = data_seen_r;
    xor_sum_nxt          = xor_sum_r;
    hex_digits_nxt       = hex_digits_r;
    hex_value_nxt        = hex_value_r;
    hex_bad_nxt          = hex_bad_r;
    comma_count_nxt      = comma_count_r;
    count_value_nxt      = count_value_r;
    count_phase_nxt      = count_phase_r;
    number_value_nxt     = number_value_r;
    number_phase_nxt     = number_phase_r;
    payload_stopped_nxt  = payload_stopped_r;
    payload_nonempty_nxt = payload_nonempty_r;
    emit_sym             = 1'b0;
    cnt_step             = dec_feed(b, count_value_r, count_phase_r);
    num_step             = dec_feed(b, number_value_r, number_phase_r);

    // checksum framing
    if (star_seen_r) begin
      if (hex_digits_r != 2'd2) begin
        if (hex_nib[4]) begin
          hex_value_nxt  = {hex_value_r[3:0], hex_nib[3:0]};
          hex_digits_nxt = hex_digits_r + 2'd1;
        end else begin
          if (hex_digits_r == 2'd0) hex_bad_nxt = 1'b1;
          hex_digits_nxt = 2'd2;
        end
      end
    end else if (b == CH_STAR) begin
      if (!start_seen_r || !data_seen_r) framing_bad_nxt = 1'b1;
      star_seen_nxt = 1'b1;
    end else if (start_seen_r) begin
      xor_sum_nxt   = xor_sum_r ^ b;
      data_seen_nxt = 1'b1;
    end else if (b inside {CH_DOLLAR, CH_BANG}) begin
      start_seen_nxt = 1'b1;
    end

    // field tracking
    if (b == CH_COMMA) begin
      if (comma_count_r != 4'd15) comma_count_nxt = comma_count_r + 4'd1;
    end else begin
      if (comma_count_r == cfg_i.count_field) begin
        {count_phase_nxt, count_value_nxt} = cnt_step;
      end
      if (comma_count_r == cfg_i.number_field) begin
        {number_phase_nxt, number_value_nxt} = num_step;
      end
      if (comma_count_r == cfg_i.payload_field && !payload_stopped_r) begin
        if (b == CH_STAR) begin
          payload_stopped_nxt = 1'b1;
        end else begin
          emit_sym             = 1'b1;
          payload_nonempty_nxt = 1'b1;
        end
      end
    end

    run.has_sym         = emit_sym;
    run.symbol          = dearmor(b);
    run.has_stat        = stage_last_r;
    run.checksum_ok     = start_seen_nxt & star_seen_nxt & ~framing_bad_nxt & ~hex_bad_nxt &
                          (hex_digits_nxt != 2'd0) & ~xor_sum_nxt[7] &
                          (xor_sum_nxt == hex_value_nxt);
    run.fragment_count  = dec_result(count_value_nxt, count_phase_nxt);
    run.fragment_number = dec_result(number_value_nxt, number_phase_nxt);
    run.has_payload     = payload_nonempty_nxt;
  end

  assign push_o = fire & (emit_sym | stage_last_r);
  assign run_o  = run;

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && stage_last_r)) begin
      // drop the whole sentence state after the status byte
      start_seen_r       <= 1'b0;
      star_seen_r        <= 1'b0;
      framing_bad_r      <= 1'b0;
      data_seen_r        <= 1'b0;
      xor_sum_r          <= '0;
      hex_digits_r       <= '0;
      hex_value_r        <= '0;
      hex_bad_r          <= 1'b0;
      comma_count_r      <= '0;
      count_value_r      <= '0;
      count_phase_r      <= PH_EMPTY;
      number_value_r     <= '0;
      number_phase_r     <= PH_EMPTY;
      payload_stopped_r  <= 1'b0;
      payload_nonempty_r <= 1'b0;
    end else if (fire) begin
      start_seen_r       <= start_seen_nxt;
      star_seen_r        <= star_seen_nxt;
      framing_bad_r      <= framing_bad_nxt;
      data_seen_r        <= data_seen_nxt;
      xor_sum_r          <= xor_sum_nxt;
      hex_digits_r       <= hex_digits_nxt;
      hex_value_r        <= hex_value_nxt;
      hex_bad_r          <= hex_bad_nxt;
      comma_count_r      <= comma_count_nxt;
      count_value_r      <= count_value_nxt;
      count_phase_r      <= count_phase_nxt;
      number_value_r     <= number_value_nxt;
      number_phase_r     <= number_phase_nxt;
      payload_stopped_r  <= payload_stopped_nxt;
      payload_nonempty_r <= payload_nonempty_nxt;
    end
  end

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && stage_last_r) |=> (comma_count_r == 4'd0 && !star_seen_r && !start_seen_r))
    else $error("sentence state not cleared after last byte");

  a_digits_need_star: assert property (@(posedge clk) disable iff (!rst_n)
    (hex_digits_r != 2'd0) |-> star_seen_r)
    else $error("checksum digits taken without a star");
`endif

endmodule

// File: rtl/core/aivd_out_queue.sv
`timescale 1ns / 1ps

module aivd_out_queue import aivd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_i,
  input  aivd_run_t  run_i,
  output logic       q_ready_o,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [5:0] out_symbol,
  output logic       out_checksum_ok,
  output logic [7:0] out_fragment_count,
  output logic [7:0] out_fragment_number,
  output logic       out_has_payload,
  output logic       out_end_of_run
);

  aivd_run_t  mem_r [2];
  logic       head_r, tail_r;
  logic [1:0] count_r, count_nxt;
  logic       sub_r;
  logic       show_sym;
  logic       take;
  logic       pop;
  aivd_run_t  head;

  assign head      = mem_r[head_r];
  assign q_ready_o = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign show_sym  = head.has_sym & ~sub_r;
  assign take      = out_valid & out_ready;
  // an entry leaves after its final result transfer
  assign pop       = take & ~(show_sym & head.has_stat);

  assign out_kind            = ~show_sym;
  assign out_symbol          = show_sym ? head.symbol : 6'd0;
  assign out_checksum_ok     = show_sym ? 1'b0 : head.checksum_ok;
  assign out_fragment_count  = show_sym ? 8'd0 : head.fragment_count;
  assign out_fragment_number = show_sym ? 8'd0 : head.fragment_number;
  assign out_has_payload     = show_sym ? 1'b0 : head.has_payload;
  assign out_end_of_run      = show_sym ? ~head.has_stat : 1'b1;

  always_comb begin
    count_nxt = count_r;
    case ({push_i, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      tail_r  <= 1'b0;
      count_r <= '0;
      sub_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push_i) tail_r <= ~tail_r;
      if (pop) begin
        head_r <= ~head_r;
        sub_r  <= 1'b0;
      end else if (take) begin
        sub_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) mem_r[tail_r] <= run_i;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (count_r != 2'd2))
    else $error("result queue overflow");

  a_sub_only_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (count_r != 2'd0 && head.has_sym && head.has_stat))
    else $error("second result selected on an entry without two results");
`endif

endmodule

// File: rtl/core/aivdm_sentence_parser.sv
`timescale 1ns / 1ps

// Channel | Handshake          | Payload
// in_     | in_valid/in_ready  | in_byte_req[7:0], in_last
// out_    | out_valid/out_ready| kind, symbol, checksum_ok, fragment_count/number,
//         |                    | has_payload, end_of_run
// cfg     | psel/penable/pready| paddr[3:0], pwrite, pwdata, prdata (32 bits)
//
// One byte is accepted per cycle while the result queue has room; its results
// pass through the input register and then the result queue to the output.
// A byte that yields a symbol and a status needs two output transfers, and the
// output gives one per cycle, so the input may stall then.
// Reset sets payload/count/number field to 5/1/2 and clears the sentence state.
// A stalled output fills the two-entry result queue, then in_ready drops.

module aivdm_sentence_parser import aivd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte_req,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output logic [5:0]       out_symbol,
  output logic             out_checksum_ok,
  output logic [7:0]       out_fragment_count,
  output logic [7:0]       out_fragment_number,
  output logic             out_has_payload,
  output logic             out_end_of_run,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  aivd_cfg_t cfg;
  aivd_run_t run;
  logic      push;
  logic      q_ready;

  aivd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  aivd_parse_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte_req (in_byte_req),
    .in_last     (in_last),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .run_o       (run)
  );

  aivd_out_queue u_queue (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push_i              (push),
    .run_i               (run),
    .q_ready_o           (q_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_symbol          (out_symbol),
    .out_checksum_ok     (out_checksum_ok),
    .out_fragment_count  (out_fragment_count),
    .out_fragment_number (out_fragment_number),
    .out_has_payload     (out_has_payload),
    .out_end_of_run      (out_end_of_run)
  );

endmodule
